>>> rtl/core/assert_macros.svh
// Assertion macros for the top-level RTL file; they compile away under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

>>> rtl/core/atbb_pkg.sv
// Shared constants and types of the alpha trim bounding box unit.
package atbb_pkg;

  localparam int unsigned MaxDimensionDefault = 4096;
  localparam int unsigned CfgDataW            = 13;
  localparam int unsigned CfgIdxW             = 2;
  localparam int unsigned AlphaW              = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth   = 2'd0,
    CfgImageHeight  = 2'd1,
    CfgAlphaPresent = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CfgDataW-1:0] image_width;
    logic [CfgDataW-1:0] image_height;
    logic                alpha_present;
  } cfg_t;

endpackage

>>> rtl/core/atbb_tracker.sv
// Position counters, visible-pixel box trackers and frame result logic.
module atbb_tracker #(
  parameter int unsigned MaxDimension = atbb_pkg::MaxDimensionDefault,
  parameter int unsigned CountW       = $clog2(MaxDimension)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  atbb_pkg::cfg_t              cfg_i,
  input  logic                        accept_i,
  input  logic [atbb_pkg::AlphaW-1:0] alpha_i,
  output logic                        res_valid_o,
  output logic [CountW-1:0]           res_left_o,
  output logic [CountW-1:0]           res_top_o,
  output logic [CountW:0]             res_width_o,
  output logic [CountW:0]             res_height_o
);
  import atbb_pkg::*;

  localparam int unsigned SizeW = CountW + 1;

  function automatic logic [SizeW-1:0] clamp_size(input logic [CfgDataW-1:0] v);
    if (v == '0) begin
      return SizeW'(1);
    end else if (32'(v) > 32'(MaxDimension)) begin
      return SizeW'(MaxDimension);
    end else begin
      return SizeW'(v);
    end
  endfunction

  logic [SizeW-1:0]  w_eff, h_eff;
  logic              last_col, last_row, frame_end, visible;
  logic [CountW-1:0] col_q, col_d, row_q, row_d;
  logic [CountW-1:0] lc_q, lc_d, gc_q, gc_d, lr_q, lr_d, gr_q, gr_d;
  logic [CountW-1:0] lc_u, gc_u, lr_u, gr_u;
  logic              seen_q, seen_d, seen_u;

  assign w_eff     = clamp_size(cfg_i.image_width);
  assign h_eff     = clamp_size(cfg_i.image_height);
  // A counter at or past the last position counts as on it, so a size
  // change mid-frame ends the row or frame there.
  assign last_col  = {1'b0, col_q} >= (w_eff - SizeW'(1));
  assign last_row  = {1'b0, row_q} >= (h_eff - SizeW'(1));
  assign frame_end = accept_i && last_col && last_row;
  assign visible   = cfg_i.alpha_present && (alpha_i != '0);

  always_comb begin
    lc_u   = lc_q;
    gc_u   = gc_q;
    lr_u   = lr_q;
    gr_u   = gr_q;
    seen_u = seen_q;
    if (accept_i && visible) begin
      seen_u = 1'b1;
      if (!seen_q) begin
        lc_u = col_q;
        gc_u = col_q;
        lr_u = row_q;
        gr_u = row_q;
      end else begin
        if (col_q < lc_q) lc_u = col_q;
        if (col_q > gc_q) gc_u = col_q;
        if (row_q < lr_q) lr_u = row_q;
        if (row_q > gr_q) gr_u = row_q;
      end
    end
  end

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    lc_d   = lc_u;
    gc_d   = gc_u;
    lr_d   = lr_u;
    gr_d   = gr_u;
    seen_d = seen_u;
    if (accept_i) begin
      if (!last_col) begin
        col_d = col_q + CountW'(1);
      end else begin
        col_d = '0;
        if (!last_row) begin
          row_d = row_q + CountW'(1);
        end else begin
          row_d = '0;
        end
      end
    end
    if (frame_end) begin
      lc_d   = '1;
      gc_d   = '0;
      lr_d   = '1;
      gr_d   = '0;
      seen_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      lc_q   <= '1;
      gc_q   <= '0;
      lr_q   <= '1;
      gr_q   <= '0;
      seen_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      lc_q   <= lc_d;
      gc_q   <= gc_d;
      lr_q   <= lr_d;
      gr_q   <= gr_d;
      seen_q <= seen_d;
    end
  end

  assign res_valid_o = frame_end;

  always_comb begin
    res_left_o   = '0;
    res_top_o    = '0;
    res_width_o  = '0;
    res_height_o = '0;
    if (!cfg_i.alpha_present) begin
      res_width_o  = w_eff;
      res_height_o = h_eff;
    end else if (seen_u) begin
      res_left_o   = lc_u;
      res_top_o    = lr_u;
      res_width_o  = {1'b0, gc_u} - {1'b0, lc_u} + SizeW'(1);
      res_height_o = {1'b0, gr_u} - {1'b0, lr_u} + SizeW'(1);
    end
  end

endmodule

>>> rtl/core/atbb_out_buf.sv
// Output register with one skid entry for frame results.
module atbb_out_buf #(
  parameter int unsigned DataW = 50
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [DataW-1:0] in_data_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [DataW-1:0] out_data_o
);
  import atbb_pkg::*;

  logic             out_v_q, out_v_d, skid_v_q, skid_v_d;
  logic [DataW-1:0] out_q, out_d, skid_q, skid_d;

  // The skid entry only fills while the output register is held, and the
  // input side is stopped while it is full, so no result is ever dropped.
  always_comb begin
    out_v_d  = out_v_q;
    out_d    = out_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (!out_v_q || !out_stall_i) begin
      if (skid_v_q) begin
        out_v_d  = 1'b1;
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end else begin
        out_v_d = in_valid_i;
        out_d   = in_data_i;
      end
    end else if (in_valid_i) begin
      skid_v_d = 1'b1;
      skid_d   = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_v_q;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/core/alpha_trim_bounding_box_unit.sv
// Top level of the alpha trim bounding box unit: config registers and datapath.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------
//  in      | input     | in_valid_i, in_stall_o | alpha_i
//  out     | output    | out_valid_o, out_stall_i | trim_left/top/width/height_o
//  cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// One pixel is taken per clock while the input is not stalled; counters and trackers are registered.
// A frame result is registered in the output buffer (or its skid entry while the output is stalled).
// Reset clears the counters, empties the trackers and sets width 1, height 1, alpha on.
// The input stalls only while a second result waits behind a stalled output.
`include "assert_macros.svh"
module alpha_trim_bounding_box_unit #(
  parameter int unsigned MaxDimension = atbb_pkg::MaxDimensionDefault,
  parameter int unsigned CountW       = $clog2(MaxDimension)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [atbb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [atbb_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [atbb_pkg::AlphaW-1:0]   alpha_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [CountW-1:0]             trim_left_o,
  output logic [CountW-1:0]             trim_top_o,
  output logic [CountW:0]               trim_width_o,
  output logic [CountW:0]               trim_height_o
);
  import atbb_pkg::*;

  localparam int unsigned DataW = 4 * CountW + 2;

  cfg_t              cfg_q, cfg_d;
  logic              accept;
  logic              res_valid;
  logic [CountW-1:0] res_left, res_top;
  logic [CountW:0]   res_width, res_height;
  logic [DataW-1:0]  out_data;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgImageWidth:   cfg_d.image_width   = cfg_data_i;
        CfgImageHeight:  cfg_d.image_height  = cfg_data_i;
        CfgAlphaPresent: cfg_d.alpha_present = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width   <= CfgDataW'(1);
      cfg_q.image_height  <= CfgDataW'(1);
      cfg_q.alpha_present <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign accept = in_valid_i && !in_stall_o;

  atbb_tracker #(
    .MaxDimension (MaxDimension),
    .CountW       (CountW)
  ) u_tracker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .accept_i     (accept),
    .alpha_i      (alpha_i),
    .res_valid_o  (res_valid),
    .res_left_o   (res_left),
    .res_top_o    (res_top),
    .res_width_o  (res_width),
    .res_height_o (res_height)
  );

  atbb_out_buf #(
    .DataW (DataW)
  ) u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_data_i   ({res_left, res_top, res_width, res_height}),
    .full_o      (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign {trim_left_o, trim_top_o, trim_width_o, trim_height_o} = out_data;

  `ASSERT_PROP(a_stall_only_behind_result, clk_i, rst_ni, in_stall_o |-> out_valid_o, "input stalled with no result waiting")
  `ASSERT_PROP(a_result_follows_transfer, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o), "result appeared without an input transfer")
  `ASSERT_NEVER(a_empty_box_all_zero, clk_i, rst_ni, out_valid_o && (trim_width_o == '0) && ((trim_height_o != '0) || (trim_left_o != '0) || (trim_top_o != '0)), "empty box with nonzero fields")

endmodule
